[rtl/utf8_stream_decoder_assert.svh]
// assertion macros used by the utf8 stream decoder rtl (utf8sd_decode)
// expects clk and rst to be visible in the module that uses them
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define UTF8SD_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define UTF8SD_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[rtl/utf8sd_pkg.sv]
// shared types and constants of the utf8 stream decoder
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned PendW = 3;

  // lead and continuation prefix masks and patterns
  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [ByteW-1:0] ContMask   = 8'hC0;
  localparam logic [ByteW-1:0] ContPat    = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat   = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat   = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat   = 8'hF0;
  localparam logic [ByteW-1:0] Lead5Mask  = 8'hFC;
  localparam logic [ByteW-1:0] Lead5Pat   = 8'hF8;
  localparam logic [ByteW-1:0] Lead6Mask  = 8'hFE;
  localparam logic [ByteW-1:0] Lead6Pat   = 8'hFC;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             last_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_error;
    logic           end_of_string;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/utf8sd_in_stage.sv]
// input register of the utf8 stream decoder: holds one accepted byte beat
// depends on utf8sd_pkg for the beat type
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_in_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                src_valid,
  output logic                     src_ready,
  input  wire utf8sd_pkg::in_beat_t src_data,
  output logic                     beat_valid,
  input  wire logic                beat_take,
  output utf8sd_pkg::in_beat_t     beat
);
  import utf8sd_pkg::*;

  logic     valid;
  in_beat_t data;

  // free when empty or when the held beat leaves this cycle
  assign src_ready  = !valid || beat_take;
  assign beat_valid = valid;
  assign beat       = data;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (src_ready) begin
      valid <= src_valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      data <= src_data;
    end
  end

endmodule

`default_nettype wire

[rtl/utf8sd_decode.sv]
// sequence state and single-pass byte decode of the utf8 stream decoder
// depends on utf8sd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module utf8sd_decode (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 beat_valid,
  output logic                      beat_take,
  input  wire utf8sd_pkg::in_beat_t beat,
  input  wire logic                 res_free,
  output logic                      res_load,
  output utf8sd_pkg::out_beat_t     res_beat
);
  import utf8sd_pkg::*;

  logic             ucs2_mode;
  logic [PendW-1:0] pending;
  logic [PendW-1:0] pending_next;
  logic [CpW-1:0]   partial;
  logic [CpW-1:0]   partial_next;
  logic             skip;
  logic             skip_next;
  logic             emit;
  logic             fail;
  logic [CpW-1:0]   shifted;
  logic [PendW-1:0] lead_need;
  logic [CpW-1:0]   lead_bits;
  logic             lead_ok;
  logic [ByteW-1:0] b;
  logic             last;

  assign b         = beat.byte_in;
  assign last      = beat.last_of_string;
  // a byte that gives no result never waits for the result register
  assign beat_take = beat_valid && (res_free || !emit);
  assign shifted   = {partial[CpW-7:0], b[5:0]};

  // lead byte classification, exact prefix match
  always_comb begin
    lead_ok   = 1'b1;
    lead_need = '0;
    lead_bits = '0;
    priority if ((b & Lead2Mask) == Lead2Pat) begin
      lead_need = PendW'(1);
      lead_bits = CpW'(b[4:0]);
    end else if ((b & Lead3Mask) == Lead3Pat) begin
      lead_need = PendW'(2);
      lead_bits = CpW'(b[3:0]);
    end else if ((b & Lead4Mask) == Lead4Pat && !ucs2_mode) begin
      lead_need = PendW'(3);
      lead_bits = CpW'(b[2:0]);
    end else if ((b & Lead5Mask) == Lead5Pat && !ucs2_mode) begin
      lead_need = PendW'(4);
      lead_bits = CpW'(b[1:0]);
    end else if ((b & Lead6Mask) == Lead6Pat && !ucs2_mode) begin
      lead_need = PendW'(5);
      lead_bits = CpW'(b[0]);
    end else begin
      lead_ok = 1'b0;
    end
  end

  // next state and result for the byte in the input register
  always_comb begin
    pending_next = pending;
    partial_next = partial;
    skip_next    = skip;
    emit         = 1'b0;
    fail         = 1'b0;
    res_beat     = '0;
    if (skip) begin
      if (last) begin
        skip_next = 1'b0;
      end
    end else if (pending != '0) begin
      if ((b & ContMask) != ContPat) begin
        fail = 1'b1;
      end else if (pending == PendW'(1)) begin
        emit                   = 1'b1;
        res_beat.code_point    = shifted;
        res_beat.end_of_string = last;
        pending_next           = '0;
        partial_next           = '0;
      end else if (last) begin
        fail = 1'b1;
      end else begin
        pending_next = pending - PendW'(1);
        partial_next = shifted;
      end
    end else if (b < AsciiLimit) begin
      emit                   = 1'b1;
      res_beat.code_point    = CpW'(b);
      res_beat.end_of_string = last;
    end else if (!lead_ok || last) begin
      fail = 1'b1;
    end else begin
      pending_next = lead_need;
      partial_next = lead_bits;
    end
    // error result clears the sequence and may start skipping
    if (fail) begin
      emit                   = 1'b1;
      res_beat               = '0;
      res_beat.is_error      = 1'b1;
      res_beat.end_of_string = 1'b1;
      pending_next           = '0;
      partial_next           = '0;
      skip_next              = !last;
    end
  end

  assign res_load = beat_take && emit;

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      partial <= '0;
      skip    <= 1'b0;
    end else if (beat_take) begin
      pending <= pending_next;
      partial <= partial_next;
      skip    <= skip_next;
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      ucs2_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      ucs2_mode <= cfg_wr_data;
    end
  end

  `UTF8SD_ASSERT_NOW(a_skip_idle_seq, skip, pending == '0, "skipping with a sequence open")
  `UTF8SD_ASSERT_NOW(a_partial_clear, pending == '0, partial == '0, "stale partial value")
  `UTF8SD_ASSERT_NEXT(a_last_closes, beat_take && last, pending == '0 && !skip,
    "string end left state open")
  `UTF8SD_ASSERT_NEXT(a_err_skips, res_load && res_beat.is_error && !last, skip,
    "error mid-string did not start skipping")

endmodule

`default_nettype wire

[rtl/utf8sd_out_stage.sv]
// result register of the utf8 stream decoder: holds one result beat
// depends on utf8sd_pkg for the beat type
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  output logic                       res_free,
  input  wire logic                  res_load,
  input  wire utf8sd_pkg::out_beat_t res_beat,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output utf8sd_pkg::out_beat_t      res_data
);
  import utf8sd_pkg::*;

  logic      valid;
  out_beat_t data;

  // can take a new result when empty or draining this cycle
  assign res_free  = !valid || res_ready;
  assign res_valid = valid;
  assign res_data  = data;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_free) begin
      valid <= res_load;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (res_free && res_load) begin
      data <= res_beat;
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_stream_decoder.sv]
// utf8 stream decoder
//
// src channel: one utf8 byte per beat with a flag on the last byte of a string.
// res channel: one code point per finished sequence, or one error beat for a
// bad lead, bad continuation or a sequence cut short by the string end. An
// error beat carries code point zero and always ends the string; the rest of
// that string's bytes give no beat.
// cfg_wr_en / cfg_wr_data write the ucs2 mode bit (sequences of at most three
// bytes); the mode is sampled when a lead byte is decoded.
// path: a byte held in the input register is decoded combinationally into the
// result register; two register stages (input register, result register).
// throughput: one byte per cycle unless stalled; the sequence state updates per
// byte taken, so any mix of ascii and multi-byte text flows without gaps.
// reset: clears the valid flags of both stage registers, the sequence state and the mode bit.
// stall: while res_ready is low the result register holds its beat; the input
// register keeps taking bytes until a byte that needs the result register
// finds it full, then src_ready drops until the beat leaves.
// depends on utf8sd_pkg, utf8sd_in_stage, utf8sd_decode, utf8sd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 src_valid,
  output logic                      src_ready,
  input  wire utf8sd_pkg::in_beat_t src_data,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output utf8sd_pkg::out_beat_t     res_data
);
  import utf8sd_pkg::*;

  logic      beat_valid;
  logic      beat_take;
  in_beat_t  beat;
  logic      res_free;
  logic      res_load;
  out_beat_t res_beat;

  // input register
  utf8sd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_data   (src_data),
    .beat_valid (beat_valid),
    .beat_take  (beat_take),
    .beat       (beat)
  );

  // decode and sequence state
  utf8sd_decode u_dec (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat_valid  (beat_valid),
    .beat_take   (beat_take),
    .beat        (beat),
    .res_free    (res_free),
    .res_load    (res_load),
    .res_beat    (res_beat)
  );

  // result register
  utf8sd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_free  (res_free),
    .res_load  (res_load),
    .res_beat  (res_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire
